// File: design/lpsc_pkg.sv
// Package for the local peak share counter: field widths, configuration
// register map, share mode codes and the saturating count helper.
// No dependencies.
`timescale 1ns / 1ps

package lpsc_pkg;

  localparam int SAMPLE_W        = 8;
  localparam int COUNT_W         = 32;
  localparam int MAX_WORKERS_DEF = 8;
  localparam int LENGTH_BITS_DEF = 32;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SHARE_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORKER_INDEX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORKER_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ARRAY_LENGTH = 2'd3;

  // share mode codes
  localparam logic [1:0] MODE_BLOCK_LEFT  = 2'd0;
  localparam logic [1:0] MODE_BLOCK_RIGHT = 2'd1;
  localparam logic [1:0] MODE_CYCLIC      = 2'd2;
  localparam logic [1:0] MODE_REV_CYCLIC  = 2'd3;

  typedef struct packed {
    logic [1:0]  share_mode;
    logic [2:0]  worker_index;
    logic [3:0]  worker_count;
    logic [31:0] array_length;
  } cfg_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v,
                                                 input logic en);
    if (en && (v != '1)) begin
      return v + COUNT_W'(1);
    end
    return v;
  endfunction

endpackage

// File: design/lpsc_sample_if.sv
// Sample request channel: valid/ready handshake with one unsigned byte.
// Depends on lpsc_pkg.
`timescale 1ns / 1ps

interface lpsc_sample_if import lpsc_pkg::*;;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// File: design/lpsc_count_if.sv
// Result request channel: valid/ready handshake carrying the peak count.
// Depends on lpsc_pkg.
`timescale 1ns / 1ps

interface lpsc_count_if import lpsc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] peak_count;

  modport source (output valid, output peak_count, input ready);
  modport sink   (input valid, input peak_count, output ready);
endinterface

// File: design/lpsc_share_calc.sv
// Share bound unit: two small multiplies, then two bit-serial divisions by the
// worker count, giving the share low/high bounds. Depends on lpsc_pkg.
`timescale 1ns / 1ps

module lpsc_share_calc import lpsc_pkg::*; #(
  parameter int MAX_WORKERS = MAX_WORKERS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 restart_i,
  input  logic [1:0]                           mode_i,
  input  logic [2:0]                           rank_i,
  input  logic [LENGTH_BITS-1:0]               len_i,
  input  logic [$clog2(MAX_WORKERS+1)-1:0]     workers_i,
  output logic [LENGTH_BITS-1:0]               low_o,
  output logic [LENGTH_BITS-1:0]               high_o,
  output logic                                 ready_o
);

  localparam int LB = LENGTH_BITS;
  localparam int WB = $clog2(MAX_WORKERS + 1);
  localparam int DW = LB + WB;
  localparam int CB = $clog2(DW);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_DIV_A = 2'd1;
  localparam logic [1:0] ST_DIV_B = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [CB-1:0] cnt_q;
  logic [DW-1:0] dq_q, numb_q;
  logic [WB-1:0] rem_q, div_q, rem_a_q;
  logic [LB-1:0] len_q, quo_a_q, low_q, high_q;
  logic [2:0]    rank_q;
  logic [1:0]    mode_q;
  logic          empty_q, short_q;

  // load-time operands
  logic          empty, short_len;
  logic [WB-1:0] rank_w, k_a, k_b, q_rank;
  logic [DW-1:0] num_a, num_b;

  // divider step
  logic [WB:0]   trial;
  logic          ge;
  logic [WB-1:0] rem_nx;
  logic [DW-1:0] dq_nx;
  logic          last_step;

  // final bounds
  logic [LB-1:0] quo_b, low_d, high_d;

  always_comb begin
    empty     = 8'(rank_i) >= 8'(workers_i);
    short_len = (len_i - LB'(1)) < LB'(rank_i);
    rank_w    = WB'(rank_i);
    q_rank    = workers_i - WB'(1) - rank_w;
    k_a       = '0;
    k_b       = '0;
    case (mode_i)
      MODE_BLOCK_LEFT: begin
        k_a = rank_w;
        k_b = rank_w + WB'(1);
      end
      MODE_BLOCK_RIGHT: begin
        k_a = q_rank + WB'(1);
        k_b = q_rank;
      end
      default: begin
        k_a = '0;
        k_b = '0;
      end
    endcase
    num_b = DW'(k_b) * DW'(len_i);
    if (mode_i == MODE_REV_CYCLIC) begin
      num_a = DW'(len_i - LB'(1) - LB'(rank_i));
    end else begin
      num_a = DW'(k_a) * DW'(len_i);
    end
  end

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial     = {rem_q, dq_q[DW-1]};
    ge        = trial >= {1'b0, div_q};
    rem_nx    = ge ? WB'(trial - {1'b0, div_q}) : WB'(trial);
    dq_nx     = {dq_q[DW-2:0], ge};
    last_step = cnt_q == CB'(DW - 1);
  end

  always_comb begin
    quo_b  = dq_nx[LB-1:0];
    low_d  = '0;
    high_d = '0;
    case (mode_q)
      MODE_BLOCK_LEFT: begin
        low_d  = quo_a_q;
        high_d = quo_b;
      end
      MODE_BLOCK_RIGHT: begin
        low_d  = len_q - quo_a_q;
        high_d = len_q - quo_b;
      end
      MODE_CYCLIC: begin
        low_d = LB'(rank_q);
      end
      default: begin
        low_d = short_q ? LB'(div_q) : LB'(rem_a_q);
      end
    endcase
    // rank not below worker count: a phase that never matches, empty block
    if (empty_q) begin
      low_d  = LB'(div_q);
      high_d = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD:  state_d = ST_DIV_A;
      ST_DIV_A: if (last_step) state_d = ST_DIV_B;
      ST_DIV_B: if (last_step) state_d = ST_DONE;
      ST_DONE:  state_d = ST_DONE;
      default:  state_d = ST_LOAD;
    endcase
    if (restart_i) state_d = ST_LOAD;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_LOAD || last_step) begin
        cnt_q <= '0;
      end else begin
        cnt_q <= cnt_q + CB'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_LOAD: begin
        dq_q    <= num_a;
        numb_q  <= num_b;
        rem_q   <= '0;
        div_q   <= workers_i;
        len_q   <= len_i;
        rank_q  <= rank_i;
        mode_q  <= mode_i;
        empty_q <= empty;
        short_q <= short_len;
      end
      ST_DIV_A: begin
        if (last_step) begin
          quo_a_q <= dq_nx[LB-1:0];
          rem_a_q <= rem_nx;
          dq_q    <= numb_q;
          rem_q   <= '0;
        end else begin
          dq_q  <= dq_nx;
          rem_q <= rem_nx;
        end
      end
      ST_DIV_B: begin
        dq_q  <= dq_nx;
        rem_q <= rem_nx;
        if (last_step) begin
          low_q  <= low_d;
          high_q <= high_d;
        end
      end
      default: begin
      end
    endcase
  end

  assign low_o   = low_q;
  assign high_o  = high_q;
  assign ready_o = state_q == ST_DONE;

endmodule

// File: design/lpsc_scan.sv
// Sample scanner: three-sample window compare, share test, saturating
// count and the result output register. Depends on lpsc_pkg and the channels.
`timescale 1ns / 1ps

module lpsc_scan import lpsc_pkg::*; #(
  parameter int MAX_WORKERS = MAX_WORKERS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  lpsc_sample_if.sink                      sample_in,
  lpsc_count_if.source                     count_out,
  input  logic [1:0]                       mode_i,
  input  logic [LENGTH_BITS-1:0]           len_i,
  input  logic [$clog2(MAX_WORKERS+1)-1:0] workers_i,
  input  logic [LENGTH_BITS-1:0]           low_i,
  input  logic [LENGTH_BITS-1:0]           high_i,
  input  logic                             share_ready_i
);

  localparam int LB = LENGTH_BITS;
  localparam int PB = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;

  logic [LB-1:0]       pos_q;
  logic [PB-1:0]       phase_q;
  logic [SAMPLE_W-1:0] older_q, newer_q;
  logic [COUNT_W-1:0]  count_q, out_count_q;
  logic                out_valid_q;

  logic                first, last, cyclic, fire;
  logic [PB:0]         phase_inc;
  logic [PB-1:0]       phase_nx;
  logic [LB-1:0]       prev_idx;
  logic                in_prev, in_cur, peak_prev, peak_cur;
  logic [COUNT_W-1:0]  cnt_mid, cnt_total;
  logic [SAMPLE_W-1:0] s;

  always_comb begin
    s         = sample_in.sample;
    first     = pos_q == '0;
    last      = pos_q >= (len_i - LB'(1));
    cyclic    = (mode_i == MODE_CYCLIC) || (mode_i == MODE_REV_CYCLIC);
    phase_inc = {1'b0, phase_q} + (PB+1)'(1);
    if (first || (phase_inc >= (PB+1)'(workers_i))) begin
      phase_nx = '0;
    end else begin
      phase_nx = phase_inc[PB-1:0];
    end
    prev_idx = pos_q - LB'(1);
    in_prev  = cyclic ? (LB'(phase_q) == low_i)
                      : ((prev_idx >= low_i) && (prev_idx < high_i));
    in_cur   = cyclic ? (LB'(phase_nx) == low_i)
                      : ((pos_q >= low_i) && (pos_q < high_i));
    // previous position is decided now that its right neighbor is here
    peak_prev = !first && ((pos_q < LB'(2)) || (newer_q >= older_q)) &&
                (newer_q >= s) && in_prev;
    peak_cur  = (first || (s >= newer_q)) && in_cur;
    cnt_mid   = first ? '0 : sat_inc(count_q, peak_prev);
    cnt_total = sat_inc(cnt_mid, peak_cur);
  end

  assign sample_in.ready = share_ready_i &&
                           (!last || !out_valid_q || count_out.ready);
  assign fire = sample_in.valid && sample_in.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      phase_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        if (last) begin
          pos_q   <= '0;
          phase_q <= '0;
          count_q <= '0;
        end else begin
          pos_q   <= pos_q + LB'(1);
          phase_q <= phase_nx;
          count_q <= cnt_mid;
        end
      end
      if (fire && last) begin
        out_valid_q <= 1'b1;
      end else if (count_out.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      if (last) begin
        older_q     <= '0;
        newer_q     <= '0;
        out_count_q <= cnt_total;
      end else begin
        older_q <= newer_q;
        newer_q <= s;
      end
    end
  end

  assign count_out.valid      = out_valid_q;
  assign count_out.peak_count = out_count_q;

endmodule

// File: design/local_peak_share_counter_core.sv
// Top level of the local peak share counter: configuration registers,
// share bound unit and sample scanner. Depends on lpsc_pkg and the channels.
`timescale 1ns / 1ps

// The block scans an array of unsigned bytes, one sample per request on
// sample_in in index order, and counts the local maxima (greater than or
// equal to every existing neighbor) that fall in this worker's share: a
// block from the left, a block from the right, cyclic or reverse cyclic.
// On the sample that ends the array (position array_length-1) one request
// with the count goes out on count_out; other samples give no result. The
// scanner takes one sample per cycle with no gaps between arrays; the
// result sits in an output register, so samples keep flowing while it
// waits, and only the last sample of the next array stalls behind an
// untaken result. The share bounds come from a bit-serial divider by the
// worker count: after reset and after every configuration write it runs
// anew, and sample_in.ready stays low until it is done. Write
// configuration only while no array is in progress.
module local_peak_share_counter_core import lpsc_pkg::*; #(
  parameter int MAX_WORKERS = MAX_WORKERS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lpsc_sample_if.sink           sample_in,
  lpsc_count_if.source          count_out,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int LB = LENGTH_BITS;
  localparam int WB = $clog2(MAX_WORKERS + 1);

  cfg_t          cfg_q;
  logic [LB-1:0] len_masked, len_eff;
  logic [WB-1:0] workers_eff;
  logic [LB-1:0] share_low, share_high;
  logic          share_ready;

  // register file, plain writes, no read-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.share_mode   <= MODE_BLOCK_LEFT;
      cfg_q.worker_index <= 3'd0;
      cfg_q.worker_count <= 4'd1;
      cfg_q.array_length <= 32'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SHARE_MODE:   cfg_q.share_mode   <= cfg_data_i[1:0];
        REG_WORKER_INDEX: cfg_q.worker_index <= cfg_data_i[2:0];
        REG_WORKER_COUNT: cfg_q.worker_count <= cfg_data_i[3:0];
        REG_ARRAY_LENGTH: cfg_q.array_length <= cfg_data_i[31:0];
        default: begin
        end
      endcase
    end
  end

  // zero length means one sample; worker count clamped to 1..MAX_WORKERS
  always_comb begin
    len_masked = LB'(cfg_q.array_length);
    len_eff    = (len_masked == '0) ? LB'(1) : len_masked;
    if (cfg_q.worker_count == 4'd0) begin
      workers_eff = WB'(1);
    end else if (8'(cfg_q.worker_count) > 8'(MAX_WORKERS)) begin
      workers_eff = WB'(MAX_WORKERS);
    end else begin
      workers_eff = WB'(cfg_q.worker_count);
    end
  end

  lpsc_share_calc #(
    .MAX_WORKERS (MAX_WORKERS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_share_calc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_we_i),
    .mode_i    (cfg_q.share_mode),
    .rank_i    (cfg_q.worker_index),
    .len_i     (len_eff),
    .workers_i (workers_eff),
    .low_o     (share_low),
    .high_o    (share_high),
    .ready_o   (share_ready)
  );

  lpsc_scan #(
    .MAX_WORKERS (MAX_WORKERS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sample_in     (sample_in),
    .count_out     (count_out),
    .mode_i        (cfg_q.share_mode),
    .len_i         (len_eff),
    .workers_i     (workers_eff),
    .low_i         (share_low),
    .high_i        (share_high),
    .share_ready_i (share_ready)
  );

endmodule

// File: design/lpsc_chk.sv
// Port-level checker for the local peak share counter, bound to the top.
// Depends on local_peak_share_counter_core.
`timescale 1ns / 1ps

module lpsc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_count_i,
  input logic        cfg_we_i
);

  ap_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result request dropped while stalled");

  ap_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_count_i))
    else $error("result count changed while stalled");

  ap_cfg_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_i)
    else $error("sample taken before share bounds were recomputed");

  ap_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("result appeared without an accepted sample");

endmodule

bind local_peak_share_counter_core lpsc_chk u_lpsc_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_in.valid),
  .in_ready_i  (sample_in.ready),
  .out_valid_i (count_out.valid),
  .out_ready_i (count_out.ready),
  .out_count_i (count_out.peak_count),
  .cfg_we_i    (cfg_we_i)
);

// File: verif/local_peak_share_counter_core_tb.sv
// Self-checking testbench for local_peak_share_counter_core: directed arrays, then
// random arrays under three idle profiles, each count checked against a local predictor or a pinned value.
// Depends on lpsc_pkg, lpsc_sample_if, lpsc_count_if and the core itself.
`timescale 1ns / 1ps

module local_peak_share_counter_core_tb import lpsc_pkg::*;;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 6;       // result register plus a little margin
  localparam int HOLD_CYCLES   = 400;     // long output hold-off
  localparam int RANDOM_ITEMS  = 1400;
  localparam int LONG_LENGTH   = 500;
  localparam int CYCLE_LIMIT   = 900000;

  // One directed array: optional register setup, up to four samples
  // (first sample in the top byte) and an optional hand-written count.
  typedef struct packed {
    logic               wr;
    logic [1:0]         mode;
    logic [2:0]         rank;
    logic [3:0]         workers;
    logic [31:0]        len;
    logic [2:0]         n;
    logic [31:0]        s;
    logic               fixed;
    logic [COUNT_W-1:0] want;
  } dir_row_t;

  localparam int DIR_ROWS = 10;

  logic clk_i = 1'b0;
  logic rst_ni;

  lpsc_sample_if sample_ch ();
  lpsc_count_if  count_ch ();

  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  local_peak_share_counter_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_in  (sample_ch),
    .count_out  (count_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state: register copies and the scan state of the block.
  // ---------------------------------------------------------------------------
  logic [1:0]          cfg_mode    = MODE_BLOCK_LEFT;
  logic [2:0]          cfg_rank    = '0;
  logic [3:0]          cfg_workers = 4'd1;
  logic [31:0]         cfg_len     = 32'd1;

  logic [SAMPLE_W-1:0] two_back    = '0;
  logic [SAMPLE_W-1:0] one_back    = '0;
  logic [63:0]         scan_pos    = '0;
  logic [2:0]          scan_phase  = '0;
  logic [COUNT_W-1:0]  peak_tally  = '0;
  logic [63:0]         share_lo    = '0;
  logic [63:0]         share_hi    = '0;

  logic [COUNT_W-1:0]  expected_peaks [$];
  logic [COUNT_W-1:0]  predicted;
  logic [COUNT_W-1:0]  popped;

  // directed rows may pin the count by hand instead of using the predictor
  bit                  use_fixed   = 1'b0;
  logic [COUNT_W-1:0]  fixed_count = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_kick     = 1'b0;

  int mismatches    = 0;
  int peaks_checked = 0;
  int samples_taken = 0;
  int items_sent    = 0;
  int cycles        = 0;

  dir_row_t dir_rows [DIR_ROWS];

  function automatic logic [63:0] eff_len();
    return (cfg_len == 0) ? 64'd1 : 64'(cfg_len);
  endfunction

  // zero workers behaves as one, anything above eight as eight
  function automatic int eff_workers();
    if (cfg_workers == 0) return 1;
    if (cfg_workers > 8) return 8;
    return int'(cfg_workers);
  endfunction

  // Share bounds, latched on the first sample of each array. Cyclic modes
  // keep the target phase in share_lo; an empty share gets a phase of W,
  // which the stride phase never reaches.
  function automatic void set_share();
    logic [63:0] l, w, r, q;
    l = eff_len();
    w = 64'(eff_workers());
    r = 64'(cfg_rank);
    share_lo = '0;
    share_hi = '0;
    if (r >= w) begin
      share_lo = w;
      return;
    end
    case (cfg_mode)
      MODE_BLOCK_LEFT: begin
        share_lo = (r * l) / w;
        share_hi = ((r + 1) * l) / w;
      end
      MODE_BLOCK_RIGHT: begin
        q = w - 1 - r;
        share_lo = l - ((q + 1) * l) / w;
        share_hi = l - (q * l) / w;
      end
      MODE_CYCLIC: begin
        share_lo = r;
      end
      default: begin
        share_lo = (l - 1 < r) ? w : (l - 1 - r) % w;
      end
    endcase
  endfunction

  function automatic bit in_share(input logic [63:0] idx, input logic [2:0] phase);
    if (cfg_mode == MODE_BLOCK_LEFT || cfg_mode == MODE_BLOCK_RIGHT)
      return idx >= share_lo && idx < share_hi;
    return 64'(phase) == share_lo;
  endfunction

  function automatic void bump_tally();
    if (peak_tally != '1) peak_tally = peak_tally + 1'b1;
  endfunction

  // Advance the scan by one sample. Position q-1 is decided once its right
  // neighbor is known; the last position is decided on its own arrival.
  // Returns 1 with the array's count when this sample ends the array.
  function automatic bit scan_sample(input logic [SAMPLE_W-1:0] s,
                                     output logic [COUNT_W-1:0] total);
    logic [63:0] q, l;
    int          w;
    logic [2:0]  prev_phase;
    bit          at_end;
    w          = eff_workers();
    l          = eff_len();
    q          = scan_pos;
    prev_phase = scan_phase;
    at_end     = (q >= l - 1);
    total      = '0;
    if (q == 0) begin
      set_share();
      peak_tally = '0;
      scan_phase = '0;
    end else begin
      scan_phase = (int'(scan_phase) + 1 >= w) ? 3'd0 : scan_phase + 3'd1;
      if ((q < 2 || one_back >= two_back) && one_back >= s &&
          in_share(q - 1, prev_phase))
        bump_tally();
    end
    if (at_end) begin
      if ((q == 0 || s >= one_back) && in_share(q, scan_phase)) bump_tally();
      total      = peak_tally;
      two_back   = '0;
      one_back   = '0;
      scan_pos   = '0;
      scan_phase = '0;
      peak_tally = '0;
      return 1'b1;
    end
    two_back = one_back;
    one_back = s;
    scan_pos = q + 1;
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors: accepted samples feed the predictor, accepted counts are checked.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && sample_ch.valid && sample_ch.ready) begin
      samples_taken++;
      if (scan_sample(sample_ch.sample, predicted))
        expected_peaks.push_back(use_fixed ? fixed_count : predicted);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && count_ch.valid && count_ch.ready) begin
      if (expected_peaks.size() == 0) begin
        $error("peak_count: unexpected request, expected none, got %0d", count_ch.peak_count);
        mismatches++;
      end else begin
        popped = expected_peaks.pop_front();
        peaks_checked++;
        if (count_ch.peak_count !== popped) begin
          $error("peak_count: expected %0d, got %0d", popped, count_ch.peak_count);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random ready, plus one long hold-off counted here once kicked.
  // ---------------------------------------------------------------------------
  int  hold_left  = 0;
  bit  hold_taken = 1'b0;

  always @(posedge clk_i) begin
    if (hold_kick && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (!rst_ni) begin
      count_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      count_ch.ready <= 1'b0;
    end else begin
      count_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One register write per cycle; the caller drops the enable afterwards,
  // so back-to-back writes keep it high without a glitch.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      REG_SHARE_MODE:   cfg_mode    = data[1:0];
      REG_WORKER_INDEX: cfg_rank    = data[2:0];
      REG_WORKER_COUNT: cfg_workers = data[3:0];
      default:          cfg_len     = data;
    endcase
    @(posedge clk_i);
  endtask

  // Call only with the block idle; the bound divider reruns after this.
  task automatic program_share(input logic [1:0] mode, input logic [2:0] rank,
                               input logic [3:0] workers, input logic [31:0] len);
    write_reg(REG_SHARE_MODE, CFG_DATA_W'(mode));
    write_reg(REG_WORKER_INDEX, CFG_DATA_W'(rank));
    write_reg(REG_WORKER_COUNT, CFG_DATA_W'(workers));
    write_reg(REG_ARRAY_LENGTH, len);
    cfg_we <= 1'b0;
  endtask

  // Offer one sample and return on the edge that accepts it. Valid stays
  // high across back-to-back requests; it drops here only for an idle gap.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= s;
    do begin
      @(posedge clk_i);
    end while (!sample_ch.ready);
    items_sent++;
  endtask

  // Drop valid and wait until every expected count has come out.
  task automatic finish_batch();
    sample_ch.valid <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (expected_peaks.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Styles: uniform bytes, a tiny alphabet for plateaus, and the byte extremes.
  task automatic send_array(input logic [31:0] len, input int style);
    int unsigned n;
    int unsigned k;
    logic [SAMPLE_W-1:0] s;
    n = (len == 0) ? 1 : len;
    for (k = 0; k < n; k++) begin
      case (style)
        0:       s = SAMPLE_W'($urandom_range(255));
        1:       s = SAMPLE_W'($urandom_range(2));
        default: begin
          case ($urandom_range(3))
            0:       s = '0;
            1:       s = '1;
            2:       s = 8'hFE;
            default: s = SAMPLE_W'($urandom_range(255));
          endcase
        end
      endcase
      send_sample(s);
    end
  endtask

  // A random setting followed by a few back-to-back arrays of that length.
  task automatic run_random_set();
    logic [1:0]  mode;
    logic [2:0]  rank;
    logic [3:0]  workers;
    logic [31:0] len;
    int          eff, pick, narr;
    mode    = 2'($urandom_range(3));
    workers = ($urandom_range(9) < 7) ? 4'($urandom_range(8, 1)) : 4'($urandom_range(15));
    eff     = (workers == 0) ? 1 : ((workers > 8) ? 8 : int'(workers));
    // mostly a valid rank, sometimes one at or past the count
    rank    = ($urandom_range(9) < 8) ? 3'($urandom_range(eff - 1)) : 3'($urandom_range(7));
    pick    = $urandom_range(99);
    if (pick < 80)      len = $urandom_range(16, 1);
    else if (pick < 95) len = $urandom_range(96, 17);
    else                len = $urandom_range(1);   // zero behaves as one
    program_share(mode, rank, workers, len);
    narr = $urandom_range(4, 1);
    repeat (narr) send_array(len, $urandom_range(2));
    finish_batch();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int i, k, ph;
    rst_ni           = 1'b0;
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    cfg_we           = 1'b0;
    cfg_idx          = REG_SHARE_MODE;
    cfg_data         = '0;

    // wr mode rank W len n samples fixed want
    dir_rows = '{
      // reset settings, one-element array is a peak
      '{1'b0, MODE_BLOCK_LEFT, 3'd0, 4'd1, 32'd1, 3'd1, 32'h00000000, 1'b1, 32'd1},
      // plateau of two maxima between zeros
      '{1'b1, MODE_BLOCK_LEFT, 3'd0, 4'd1, 32'd4, 3'd4, 32'h00FFFF00, 1'b1, 32'd2},
      // worker count zero acts as one; both ends are peaks
      '{1'b1, MODE_BLOCK_LEFT, 3'd0, 4'd0, 32'd3, 3'd3, 32'hFF00FF00, 1'b1, 32'd2},
      // count above eight clamps; phase 7 never reached
      '{1'b1, MODE_CYCLIC, 3'd7, 4'd15, 32'd2, 3'd2, 32'h05050000, 1'b1, 32'd0},
      // rank not below count: empty share
      '{1'b1, MODE_BLOCK_LEFT, 3'd7, 4'd4, 32'd2, 3'd2, 32'h01010000, 1'b1, 32'd0},
      // length zero acts as one
      '{1'b1, MODE_BLOCK_LEFT, 3'd0, 4'd1, 32'd0, 3'd1, 32'h80000000, 1'b1, 32'd1},
      // reverse cyclic with the rank past the last index
      '{1'b1, MODE_REV_CYCLIC, 3'd3, 4'd4, 32'd2, 3'd2, 32'h09090000, 1'b1, 32'd0},
      '{1'b1, MODE_BLOCK_RIGHT, 3'd0, 4'd2, 32'd3, 3'd3, 32'h03020100, 1'b0, 32'd0},
      '{1'b1, MODE_REV_CYCLIC, 3'd1, 4'd2, 32'd4, 3'd4, 32'h01020304, 1'b0, 32'd0},
      '{1'b1, MODE_CYCLIC, 3'd1, 4'd3, 32'd3, 3'd3, 32'h00000000, 1'b0, 32'd0}
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, no idling on either side.
    for (i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].wr)
        program_share(dir_rows[i].mode, dir_rows[i].rank, dir_rows[i].workers,
                      dir_rows[i].len);
      use_fixed   = dir_rows[i].fixed;
      fixed_count = dir_rows[i].want;
      for (k = 0; k < dir_rows[i].n; k++) send_sample(dir_rows[i].s[31 - 8 * k -: 8]);
      finish_batch();
      use_fixed = 1'b0;
    end

    // all-ones length lands in the register, then gets replaced before use
    write_reg(REG_ARRAY_LENGTH, '1);

    // Random part: receiver-heavy idling, sender-heavy idling, then none.
    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 28 : ((ph == 1) ? 50 : 0);
      recv_idle_pct = (ph == 0) ? 50 : ((ph == 1) ? 28 : 0);
      if (ph == 2) begin
        // Output held off while short arrays keep streaming in: the result
        // register fills and the input stalls on the next array's end.
        program_share(MODE_CYCLIC, 3'd1, 4'd3, 32'd4);
        hold_kick = 1'b1;
        repeat (8) send_array(32'd4, 0);
        finish_batch();
        // one long array with the widest share split
        program_share(MODE_BLOCK_RIGHT, 3'd7, 4'd8, LONG_LENGTH);
        send_array(LONG_LENGTH, 0);
        finish_batch();
      end
      while (items_sent < 25 + (ph + 1) * (RANDOM_ITEMS / 3)) run_random_set();
    end

    finish_batch();
    $display("Covered %0d samples and %0d peak counts across all four share modes,",
             samples_taken, peaks_checked);
    $display("with idle gaps on both channels and one long output hold-off.");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: local_peak_share_counter_core.f
design/lpsc_pkg.sv
design/lpsc_sample_if.sv
design/lpsc_count_if.sv
design/lpsc_share_calc.sv
design/lpsc_scan.sv
design/local_peak_share_counter_core.sv
design/lpsc_chk.sv
verif/local_peak_share_counter_core_tb.sv
